/* rtl/lfu_cache_table_core_defines.svh */
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared property wrappers on the block clock with reset disable.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_CORE_DEFINES_SVH
`define LFU_CACHE_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define LFU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu cache table check failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu cache table check failed");

`endif

/* rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache table package
// Sizes, entry and control types shared by the cache table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 5;
    localparam int CAP_W       = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int TREE_LEAVES = 1 << IDX_W;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 32;
    localparam int TOUCH_W     = 64;

    localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             CMD_GET    = 1'b0;
    localparam logic             CMD_PUT    = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef logic [MAX_ENTRIES-1:0] t_slots;
    typedef logic [IDX_W-1:0]       t_idx;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [CNT_W-1:0]   cnt;
        logic [TOUCH_W-1:0] touch;
    } t_entry;

    typedef struct packed {
        logic             hit;
        t_idx             hit_idx;
        logic [VAL_W-1:0] hit_value;
        logic             free_ok;
        t_idx             free_idx;
    } t_lookup;

    typedef struct packed {
        logic             ok;
        t_idx             idx;
        logic [KEY_W-1:0] key;
    } t_victim;

    typedef struct packed {
        logic             en;
        logic             touch;
        t_idx             touch_idx;
        logic             write_value;
        logic             evict;
        t_idx             evict_idx;
        logic             insert;
        t_idx             insert_idx;
        logic             grow;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_update;

endpackage

/* rtl/lfu_cache_table_core.sv */
// ----------------------------------------------------------------------------
// LFU cache table core
// Fully associative key/value cache with LFU replacement and LRU tie break.
// ----------------------------------------------------------------------------
// Takes one get or put beat per clock while the result side is not stalled, and
// returns one result beat for each through an input register and then a result
// register, so back-to-back beats stream. The lookup between the two registers
// is combinational: a parallel key compare against all 16 entry flops and a
// four-level min-count/oldest-touch tree that picks the eviction victim.
// The table is empty after reset with no clearing pass; the capacity register
// resets to 16 and should only be written while no beat is in flight.
`timescale 1ns / 1ps

module lfu_cache_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic signed [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lfu_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic signed [lfu_pkg::VAL_W-1:0]  o_read_value,
    output logic                              o_evicted,
    output logic signed [lfu_pkg::KEY_W-1:0]  o_evicted_key
);

    logic [lfu_pkg::CFG_W-1:0] r_capacity;

    logic                      r_in_valid;
    logic                      r_command;
    logic [lfu_pkg::KEY_W-1:0] r_key;
    logic [lfu_pkg::VAL_W-1:0] r_value;

    logic                      r_out_valid;
    logic                      r_found;
    logic [lfu_pkg::VAL_W-1:0] r_read_value;
    logic                      r_evicted;
    logic [lfu_pkg::KEY_W-1:0] r_evicted_key;

    logic                      n_found;
    logic [lfu_pkg::VAL_W-1:0] n_read_value;
    logic                      n_evicted;
    logic [lfu_pkg::KEY_W-1:0] n_evicted_key;

    lfu_pkg::t_entry           w_entry [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::OCC_W-1:0] w_used;
    lfu_pkg::t_lookup          w_lookup;
    lfu_pkg::t_victim          w_victim;
    lfu_pkg::t_update          w_upd;

    logic                      w_out_free;
    logic                      w_advance;
    logic                      w_accept;
    logic [lfu_pkg::CAP_W-1:0] w_cap_eff;
    logic                      w_full;
    logic                      w_is_put;
    logic                      w_evict;
    logic                      w_insert;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = !i_rst_n || (r_in_valid && !w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lfu_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command <= i_command;
            r_key     <= i_key;
            r_value   <= i_value;
        end
    end

    lfu_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .o_entry (w_entry),
        .o_used  (w_used)
    );

    lfu_lookup u_lookup (
        .i_entry  (w_entry),
        .i_key    (r_key),
        .o_lookup (w_lookup)
    );

    lfu_victim u_victim (
        .i_entry  (w_entry),
        .o_victim (w_victim)
    );

    // clamp capacity into 1..MAX_ENTRIES
    always_comb begin
        w_cap_eff = lfu_pkg::CAP_W'(r_capacity);
        if (w_cap_eff == '0) begin
            w_cap_eff = lfu_pkg::CAP_W'(1);
        end else if (w_cap_eff > lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES)) begin
            w_cap_eff = lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES);
        end
    end

    assign w_full   = lfu_pkg::CAP_W'(w_used) >= w_cap_eff;
    assign w_is_put = (r_command == lfu_pkg::CMD_PUT);
    assign w_evict  = w_is_put && !w_lookup.hit && w_full && w_victim.ok;
    assign w_insert = w_is_put && !w_lookup.hit && (w_evict || w_lookup.free_ok);

    always_comb begin
        w_upd             = '0;
        w_upd.en          = w_advance;
        w_upd.touch       = w_lookup.hit;
        w_upd.touch_idx   = w_lookup.hit_idx;
        w_upd.write_value = w_is_put && w_lookup.hit;
        w_upd.evict       = w_evict;
        w_upd.evict_idx   = w_victim.idx;
        w_upd.insert      = w_insert;
        // refill the freed slot unless a lower one is already empty
        w_upd.insert_idx  = (w_evict && (!w_lookup.free_ok || (w_victim.idx < w_lookup.free_idx)))
                            ? w_victim.idx : w_lookup.free_idx;
        w_upd.grow        = w_insert && !w_evict;
        w_upd.key         = r_key;
        w_upd.value       = r_value;
    end

    always_comb begin
        n_found       = w_lookup.hit;
        n_evicted     = w_evict;
        n_evicted_key = w_evict ? w_victim.key : '0;
        if (w_is_put) begin
            n_read_value = '0;
        end else if (w_lookup.hit) begin
            n_read_value = w_lookup.hit_value;
        end else begin
            n_read_value = lfu_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_found       <= n_found;
            r_read_value  <= n_read_value;
            r_evicted     <= n_evicted;
            r_evicted_key <= n_evicted_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

/* rtl/lfu_lookup.sv */
// ----------------------------------------------------------------------------
// LFU key lookup
// Parallel key match, hit value select and lowest free slot search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_lookup (
    input  lfu_pkg::t_entry            i_entry [lfu_pkg::MAX_ENTRIES],
    input  logic [lfu_pkg::KEY_W-1:0]  i_key,
    output lfu_pkg::t_lookup           o_lookup
);

    lfu_pkg::t_slots w_match;
    lfu_pkg::t_slots w_free;
    lfu_pkg::t_slots w_free_oh;

    always_comb begin
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            w_match[i] = i_entry[i].valid && (i_entry[i].key == i_key);
            w_free[i]  = !i_entry[i].valid;
        end
        // isolate the lowest free slot
        w_free_oh = w_free & ((~w_free) + lfu_pkg::t_slots'(1));
    end

    always_comb begin
        o_lookup = '0;
        o_lookup.hit     = |w_match;
        o_lookup.free_ok = |w_free;
        // keys are unique, so at most one match bit is set
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                o_lookup.hit_idx   = o_lookup.hit_idx | lfu_pkg::IDX_W'(i);
                o_lookup.hit_value = o_lookup.hit_value | i_entry[i].value;
            end
            if (w_free_oh[i]) begin
                o_lookup.free_idx = o_lookup.free_idx | lfu_pkg::IDX_W'(i);
            end
        end
    end

endmodule

/* rtl/lfu_victim.sv */
// ----------------------------------------------------------------------------
// LFU victim select
// Min tree over valid entries: lowest use count, then oldest touch,
// then lowest slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_victim (
    input  lfu_pkg::t_entry  i_entry [lfu_pkg::MAX_ENTRIES],
    output lfu_pkg::t_victim o_victim
);

    typedef struct packed {
        logic                        ok;
        lfu_pkg::t_idx               idx;
        logic [lfu_pkg::CNT_W-1:0]   cnt;
        logic [lfu_pkg::TOUCH_W-1:0] touch;
    } t_cand;

    t_cand w_node [2*lfu_pkg::TREE_LEAVES-1];

    // take the right side only when strictly better, so ties go to the lower slot
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.ok && (!a.ok || (b.cnt < a.cnt) ||
                     ((b.cnt == a.cnt) && (b.touch < a.touch)))) begin
            return b;
        end
        return a;
    endfunction

    always_comb begin
        for (int i = 0; i < lfu_pkg::TREE_LEAVES; i++) begin
            if (i < lfu_pkg::MAX_ENTRIES) begin
                w_node[lfu_pkg::TREE_LEAVES-1+i] = '{ok: i_entry[i].valid,
                                                    idx: lfu_pkg::IDX_W'(i),
                                                    cnt: i_entry[i].cnt,
                                                    touch: i_entry[i].touch};
            end else begin
                w_node[lfu_pkg::TREE_LEAVES-1+i] = '{ok: 1'b0, idx: lfu_pkg::IDX_W'(i),
                                                    cnt: '0, touch: '0};
            end
        end
        for (int n = lfu_pkg::TREE_LEAVES-2; n >= 0; n--) begin
            w_node[n] = pick(w_node[2*n+1], w_node[2*n+2]);
        end
    end

    always_comb begin
        o_victim.ok  = w_node[0].ok;
        o_victim.idx = w_node[0].idx;
        o_victim.key = w_node[0].ok ? i_entry[w_node[0].idx].key : '0;
    end

endmodule

/* rtl/lfu_store.sv */
// ----------------------------------------------------------------------------
// LFU entry store
// Entry flops, touch clock and occupancy count, updated once per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_update            i_upd,
    output lfu_pkg::t_entry             o_entry [lfu_pkg::MAX_ENTRIES],
    output logic [lfu_pkg::OCC_W-1:0]   o_used
);

    lfu_pkg::t_slots             r_valid;
    logic [lfu_pkg::KEY_W-1:0]   r_key   [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::VAL_W-1:0]   r_value [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::CNT_W-1:0]   r_cnt   [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::TOUCH_W-1:0] r_touch [lfu_pkg::MAX_ENTRIES];
    logic [lfu_pkg::TOUCH_W-1:0] r_clock;
    logic [lfu_pkg::OCC_W-1:0]   r_used;

    lfu_pkg::t_slots             n_valid;
    logic [lfu_pkg::CNT_W-1:0]   w_cnt_inc;

    assign w_cnt_inc = (r_cnt[i_upd.touch_idx] == '1) ? r_cnt[i_upd.touch_idx]
                                                      : r_cnt[i_upd.touch_idx] + 1'b1;

    // clear the victim, then set the refilled slot
    always_comb begin
        n_valid = r_valid;
        if (i_upd.evict) begin
            n_valid[i_upd.evict_idx] = 1'b0;
        end
        if (i_upd.insert) begin
            n_valid[i_upd.insert_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
            r_used  <= '0;
        end else if (i_upd.en) begin
            r_valid <= n_valid;
            if (i_upd.touch || i_upd.insert) begin
                r_clock <= r_clock + lfu_pkg::TOUCH_W'(1);
            end
            if (i_upd.grow) begin
                r_used <= r_used + lfu_pkg::OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            if (i_upd.touch) begin
                r_cnt[i_upd.touch_idx]   <= w_cnt_inc;
                r_touch[i_upd.touch_idx] <= r_clock;
                if (i_upd.write_value) begin
                    r_value[i_upd.touch_idx] <= i_upd.value;
                end
            end
            if (i_upd.insert) begin
                r_key[i_upd.insert_idx]   <= i_upd.key;
                r_value[i_upd.insert_idx] <= i_upd.value;
                r_cnt[i_upd.insert_idx]   <= lfu_pkg::CNT_W'(1);
                r_touch[i_upd.insert_idx] <= r_clock;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < lfu_pkg::MAX_ENTRIES; i++) begin
            o_entry[i] = '{valid: r_valid[i], key: r_key[i], value: r_value[i],
                           cnt: r_cnt[i], touch: r_touch[i]};
        end
    end

    assign o_used = r_used;

endmodule

/* rtl/lfu_checker.sv */
// ----------------------------------------------------------------------------
// LFU cache table checker
// Port-level properties of the cache table core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lfu_cache_table_core_defines.svh"

module lfu_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_command,
    input logic signed [lfu_pkg::KEY_W-1:0]  i_key,
    input logic signed [lfu_pkg::VAL_W-1:0]  i_value,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_found,
    input logic signed [lfu_pkg::VAL_W-1:0]  o_read_value,
    input logic                              o_evicted,
    input logic signed [lfu_pkg::KEY_W-1:0]  o_evicted_key
);

    // a held input beat keeps its payload
    `LFU_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_command) && $stable(i_key) && $stable(i_value))

    // a held result beat keeps its payload
    `LFU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_found) && $stable(o_read_value) && $stable(o_evicted) && $stable(o_evicted_key))

    // input backs up only behind a stalled result
    `LFU_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // an eviction comes only from a put miss
    `LFU_ASSERT_NOW(a_evict_shape, o_out_valid && o_evicted, !o_found && (o_read_value == '0))

    // no eviction, no evicted key
    `LFU_ASSERT_NOW(a_evict_key_zero, o_out_valid && !o_evicted, o_evicted_key == '0)

endmodule

bind lfu_cache_table_core lfu_checker u_lfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .i_key         (i_key),
    .i_value       (i_value),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_read_value  (o_read_value),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);

/* bench/lfu_cache_table_core_tb.sv */
// ----------------------------------------------------------------------------
// LFU cache table core testbench
// Drives get/put beats under random idling on both channels, predicts every
// result with a behavioral copy of the table, and checks each output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_table_core_tb;

    import lfu_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_OPS   = 205;
    localparam int NUM_PHASES   = 9;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cache_op_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } cache_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_command = CMD_GET;
    logic signed [KEY_W-1:0]  i_key = '0;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_found;
    logic signed [VAL_W-1:0]  o_read_value;
    logic                     o_evicted;
    logic signed [KEY_W-1:0]  o_evicted_key;

    // Shadow copy of the table
    logic             slot_valid [MAX_ENTRIES];
    logic [KEY_W-1:0] slot_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] slot_value [MAX_ENTRIES];
    logic [CNT_W-1:0] slot_count [MAX_ENTRIES];
    logic [63:0]      slot_touch [MAX_ENTRIES];
    logic [63:0]      touch_clock = '0;
    logic [CFG_W-1:0] model_cap = CAP_RESET;

    cache_op_t     op_queue[$];
    cache_result_t pending_results[$];
    logic [KEY_W-1:0] key_pool[$];

    cache_op_t     accepted_op;
    cache_op_t     next_op;
    cache_result_t want;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int ops_accepted = 0;
    int results_checked = 0;
    int hits_expected = 0;
    int evictions_expected = 0;
    int settings_used = 1;
    int cycle_count = 0;

    logic [CFG_W-1:0] phase_cap [NUM_PHASES] = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd3,
                                                 5'd16, 5'd2, 5'd11, 5'd4};

    lfu_cache_table_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
        end
    end

    // Apply one get/put to the shadow table and return the result it must give
    function automatic cache_result_t apply_cache_op(cache_op_t op);
        cache_result_t res;
        int i;
        int hit_slot;
        int free_slot;
        int victim;
        int unsigned used;
        int unsigned cap;
        hit_slot = -1;
        free_slot = -1;
        victim = -1;
        used = 0;
        cap = 32'(model_cap);
        if (cap < 1) cap = 1;
        if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (slot_key[i] == op.key) hit_slot = i;
                if (victim < 0 || slot_count[i] < slot_count[victim] ||
                    (slot_count[i] == slot_count[victim] &&
                     slot_touch[i] < slot_touch[victim])) begin
                    victim = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        res.found = (hit_slot >= 0);
        res.read_value = '0;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        if (hit_slot >= 0) begin
            if (op.cmd == CMD_GET) res.read_value = slot_value[hit_slot];
            else slot_value[hit_slot] = op.value;
            if (slot_count[hit_slot] != '1) slot_count[hit_slot]++;
            slot_touch[hit_slot] = touch_clock;
            touch_clock++;
        end else if (op.cmd == CMD_GET) begin
            res.read_value = MISS_VALUE;
        end else begin
            if (used >= cap && victim >= 0) begin
                res.evicted = 1'b1;
                res.evicted_key = slot_key[victim];
                slot_valid[victim] = 1'b0;
                if (free_slot < 0 || victim < free_slot) free_slot = victim;
            end
            if (free_slot >= 0) begin
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot] = op.key;
                slot_value[free_slot] = op.value;
                slot_count[free_slot] = CNT_W'(1);
                slot_touch[free_slot] = touch_clock;
                touch_clock++;
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] expd);
        mismatch_count++;
        $display("%0t: %s: got %h, expected %h", $time, what, got, expd);
    endtask

    // Driver: hold a stalled beat, otherwise advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) model_cap = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                accepted_op.cmd = i_command;
                accepted_op.key = i_key;
                accepted_op.value = i_value;
                want = apply_cache_op(accepted_op);
                pending_results.push_back(want);
                ops_accepted++;
                if (want.found) hits_expected++;
                if (want.evicted) evictions_expected++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (op_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_op = op_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_command <= next_op.cmd;
                    i_key <= next_op.key;
                    i_value <= next_op.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result beat with nothing outstanding", 64'd0, 64'd0);
                end else begin
                    cache_result_t exp_res;
                    exp_res = pending_results.pop_front();
                    results_checked++;
                    if (o_found !== exp_res.found)
                        flag_mismatch("found", 64'(o_found), 64'(exp_res.found));
                    if (o_read_value !== exp_res.read_value)
                        flag_mismatch("read_value", 64'($unsigned(o_read_value)),
                                      64'(exp_res.read_value));
                    if (o_evicted !== exp_res.evicted)
                        flag_mismatch("evicted", 64'(o_evicted), 64'(exp_res.evicted));
                    if (o_evicted_key !== exp_res.evicted_key)
                        flag_mismatch("evicted_key", 64'($unsigned(o_evicted_key)),
                                      64'(exp_res.evicted_key));
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_op(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
        cache_op_t op;
        op.cmd = cmd;
        op.key = key;
        op.value = value;
        op_queue.push_back(op);
    endtask

    // Hold until every beat went in and every result came back
    task automatic wait_drained();
        @(negedge i_clk);
        while (op_queue.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
        @(negedge i_clk);
    endtask

    // Mostly pooled keys, skewed toward the front so use counts spread out
    function automatic cache_op_t make_random_op();
        cache_op_t op;
        int pick;
        pick = $urandom_range(99);
        op.cmd = ($urandom_range(99) < 45) ? CMD_PUT : CMD_GET;
        op.value = $urandom;
        if (pick < 40)
            op.key = key_pool[$urandom_range((key_pool.size() - 1) / 3)];
        else if (pick < 88)
            op.key = key_pool[$urandom_range(key_pool.size() - 1)];
        else
            op.key = $urandom;
        return op;
    endfunction

    initial begin
        int eff_cap;
        int pool_size;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes of key and value, hits and misses on both commands
        queue_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_op(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_op(CMD_GET, 32'hFFFF_FFFF, 32'h5555_5555);
        queue_op(CMD_GET, 32'h0000_0000, 32'hAAAA_AAAA);
        queue_op(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
        queue_op(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        queue_op(CMD_GET, 32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        // Shrink capacity below occupancy: each put miss evicts exactly one
        write_capacity(5'd3);
        queue_op(CMD_PUT, 32'h0000_0005, 32'h0000_0050);
        queue_op(CMD_PUT, 32'h0000_0006, 32'h0000_0060);
        queue_op(CMD_GET, 32'h0000_0006, 32'h0000_0000);
        queue_op(CMD_PUT, 32'h0000_0007, 32'h0000_0070);
        queue_op(CMD_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_op(CMD_GET, 32'h0000_0007, 32'h0000_0000);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            if (p < 3) begin
                send_gap_pct = 32;
                stall_pct = 54;
            end else if (p < 6) begin
                send_gap_pct = 54;
                stall_pct = 32;
            end else begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            eff_cap = (int'(phase_cap[p]) > MAX_ENTRIES) ? MAX_ENTRIES : int'(phase_cap[p]);
            pool_size = eff_cap + 1 + int'($urandom_range(eff_cap));
            key_pool.delete();
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(15))
                    0:       key_pool.push_back(32'h8000_0000);
                    1:       key_pool.push_back(32'h7FFF_FFFF);
                    2:       key_pool.push_back(32'hFFFF_FFFF);
                    default: key_pool.push_back($urandom);
                endcase
            end
            // Two halves with a full drain between them
            for (int half = 0; half < 2; half++) begin
                for (int n = 0; n < RANDOM_OPS / 2 + half; n++)
                    op_queue.push_back(make_random_op());
                wait_drained();
            end
        end

        repeat (10) @(negedge i_clk);
        $display("Ran %0d get/put beats over %0d capacity settings, %0d results checked",
                 ops_accepted, settings_used, results_checked);
        $display("Predicted %0d hits and %0d evictions", hits_expected, evictions_expected);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_lookup.sv
rtl/lfu_victim.sv
rtl/lfu_store.sv
rtl/lfu_cache_table_core.sv
rtl/lfu_checker.sv
bench/lfu_cache_table_core_tb.sv
